// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// ASSERT_IMPLY: when ante holds at a clock edge, cons holds at the same edge.
// ASSERT_NEXT: when ante holds at a clock edge, cons holds at the next edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/gdad_pkg.sv =====
package gdad_pkg;

   // field widths
   localparam int YEAR_IN_W  = 14;
   localparam int MONTH_W    = 4;
   localparam int DAY_IN_W   = 5;
   localparam int OFFSET_W   = 23;
   localparam int LEN_W      = 5;
   // working widths: years span about -11500..28000, day counts about +/-6.1M
   localparam int YEAR_W     = 16;
   localparam int DAYS_W     = 25;
   // year modulo 400
   localparam int RES_W      = 9;

   // stream widths
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 48;

   // months
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // commands
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_DIFF = 1'b1;

   // day window for whole-year steps, year lengths, limits
   localparam logic signed [DAYS_W-1:0] DAY_LO      = -25'sd213;
   localparam logic signed [DAYS_W-1:0] DAY_HI      = 25'sd243;
   localparam logic signed [DAYS_W-1:0] DAYS_YEAR   = 25'sd365;
   localparam logic signed [DAYS_W-1:0] DAYS_LEAP   = 25'sd366;
   localparam logic signed [DAYS_W-1:0] DAYS_MONTH  = 25'sd30;
   localparam logic signed [DAYS_W-1:0] DIFF_MAX    = 25'sd4194303;
   localparam logic signed [DAYS_W-1:0] DIFF_MIN    = -25'sd4194304;
   localparam logic signed [YEAR_W-1:0] YEAR_MAX    = 16'sd9999;
   localparam logic [RES_W-1:0]         RES_LAST    = 9'd399;
   localparam logic [RES_W-1:0]         RES_CENT1   = 9'd100;
   localparam logic [RES_W-1:0]         RES_CENT2   = 9'd200;
   localparam logic [RES_W-1:0]         RES_CENT3   = 9'd300;
   localparam logic [RES_W-1:0]         RES_MOD     = 9'd400;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_YDN,
      OP_YUP,
      OP_MDN,
      OP_MUP,
      OP_FIX,
      OP_WALKA,
      OP_WALKB,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cmd;
      logic shift_en;
      logic d_below_lo;
      logic d_above_hi;
      logic d_below_one;
      logic d_above_len;
      logic a_before_b;
      logic a_after_b;
   } dp_status_type;

   typedef struct packed {
      logic                 cmd;
      logic [YEAR_IN_W-1:0] year_a;
      logic [MONTH_W-1:0]   month_a;
      logic [DAY_IN_W-1:0]  day_a;
      logic [OFFSET_W-1:0]  day_offset;
      logic [YEAR_IN_W-1:0] year_b;
      logic [MONTH_W-1:0]   month_b;
      logic [DAY_IN_W-1:0]  day_b;
   } req_item_type;

   typedef struct packed {
      logic [YEAR_IN_W-1:0] result_year;
      logic [MONTH_W-1:0]   result_month;
      logic [DAY_IN_W-1:0]  result_day;
      logic [OFFSET_W-1:0]  day_difference;
      logic                 overflow;
   } rsp_item_type;

   // year mod 400 by restoring subtraction of 400*32 .. 400*1
   function automatic logic [RES_W-1:0] mod400(input logic [YEAR_IN_W-1:0] y);
      logic [YEAR_IN_W-1:0] v;
      v = y;
      for (int k = 5; k >= 0; k--) begin
         if (v >= YEAR_IN_W'(400 << k)) begin
            v = v - YEAR_IN_W'(400 << k);
         end
      end
      return v[RES_W-1:0];
   endfunction

   function automatic logic [RES_W-1:0] res_inc(input logic [RES_W-1:0] r);
      return (r == RES_LAST) ? '0 : r + 9'd1;
   endfunction

   function automatic logic [RES_W-1:0] res_dec(input logic [RES_W-1:0] r);
      return (r == '0) ? RES_LAST : r - 9'd1;
   endfunction

   // 4/100/400 rule on the year's residue mod 400
   function automatic logic is_leap(input logic [RES_W-1:0] r);
      return (r[1:0] == 2'b00) && (r != RES_CENT1) && (r != RES_CENT2) && (r != RES_CENT3);
   endfunction

   function automatic logic [LEN_W-1:0] month_len(input logic [RES_W-1:0] r,
                                                   input logic [MONTH_W-1:0] m);
      logic [LEN_W-1:0] n;
      case (m)
         MONTH_FEB: n = is_leap(r) ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

   function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
      logic [MONTH_W-1:0] c;
      if (m < MONTH_JAN) begin
         c = MONTH_JAN;
      end else if (m > MONTH_DEC) begin
         c = MONTH_DEC;
      end else begin
         c = m;
      end
      return c;
   endfunction

   function automatic logic signed [DAYS_W-1:0] ext_days(input logic [LEN_W-1:0] v);
      return $signed({{(DAYS_W-LEN_W){1'b0}}, v});
   endfunction

endpackage

// ===== hw/rtl/gdad_datapath.sv =====
`include "assert_macros.svh"

module gdad_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  gdad_pkg::ctrl_cmd_type ctl,
   input  gdad_pkg::req_item_type req_item,
   output gdad_pkg::dp_status_type sts,
   output gdad_pkg::rsp_item_type rsp_item
);
   import gdad_pkg::*;

   // working date A (y, y mod 400, month, day count) and day accumulator
   logic signed [YEAR_W-1:0] y_ff, y_in;
   logic [RES_W-1:0]         r_ff, r_in;
   logic [MONTH_W-1:0]       m_ff, m_in;
   logic signed [DAYS_W-1:0] d_ff, d_in;
   logic signed [DAYS_W-1:0] acc_ff, acc_in;
   // date B
   logic signed [YEAR_W-1:0] yb_ff, yb_in;
   logic [RES_W-1:0]         rb_ff, rb_in;
   logic [MONTH_W-1:0]       mb_ff, mb_in;
   logic [DAY_IN_W-1:0]      db_ff, db_in;
   // item mode
   logic                     cmd_ff, cmd_in;
   logic                     shift_ff, shift_in;
   rsp_item_type             rsp_ff, rsp_in;

   // load-time values
   logic signed [YEAR_W-1:0]  ya_s, yb_s, dy;
   logic [MONTH_W-1:0]        ma_c, mb_c;
   logic signed [MONTH_W:0]   dm;
   logic signed [DAYS_W-1:0]  da_ext, db_ext, off_ext, est;

   // per-step helpers
   logic [RES_W-1:0]   r_dec_a, r_inc_a, r_inc_b, r_dn;
   logic [MONTH_W-1:0] m_dn;
   logic [LEN_W-1:0]   len_a, len_b, len_dn;

   // first estimate of the gap: 365 per year, 30 per month, plus the day gap
   assign ya_s    = $signed({{(YEAR_W-YEAR_IN_W){1'b0}}, req_item.year_a});
   assign yb_s    = $signed({{(YEAR_W-YEAR_IN_W){1'b0}}, req_item.year_b});
   assign dy      = yb_s - ya_s;
   assign ma_c    = clamp_month(req_item.month_a);
   assign mb_c    = clamp_month(req_item.month_b);
   assign dm      = $signed({1'b0, mb_c}) - $signed({1'b0, ma_c});
   assign da_ext  = $signed({{(DAYS_W-DAY_IN_W){1'b0}}, req_item.day_a});
   assign db_ext  = $signed({{(DAYS_W-DAY_IN_W){1'b0}}, req_item.day_b});
   assign off_ext = DAYS_W'($signed(req_item.day_offset));
   assign est     = DAYS_W'(dy) * DAYS_YEAR + DAYS_W'(dm) * DAYS_MONTH + db_ext - da_ext;

   // month lengths and neighbors of the current dates
   assign r_dec_a = res_dec(r_ff);
   assign r_inc_a = res_inc(r_ff);
   assign r_inc_b = res_inc(rb_ff);
   assign len_a   = month_len(r_ff, m_ff);
   assign len_b   = month_len(rb_ff, mb_ff);
   assign m_dn    = (m_ff == MONTH_JAN) ? MONTH_DEC : m_ff - 4'd1;
   assign r_dn    = (m_ff == MONTH_JAN) ? r_dec_a : r_ff;
   assign len_dn  = month_len(r_dn, m_dn);

   // status to the controller
   assign sts.cmd         = cmd_ff;
   assign sts.shift_en    = shift_ff;
   assign sts.d_below_lo  = d_ff < DAY_LO;
   assign sts.d_above_hi  = d_ff > DAY_HI;
   assign sts.d_below_one = d_ff < 25'sd1;
   assign sts.d_above_len = d_ff > ext_days(len_a);
   assign sts.a_before_b  = (y_ff < yb_ff) || ((y_ff == yb_ff) && (m_ff < mb_ff));
   assign sts.a_after_b   = (y_ff > yb_ff) || ((y_ff == yb_ff) && (m_ff > mb_ff));

   assign rsp_item = rsp_ff;

   // one step of the selected operation
   always_comb begin
      y_in     = y_ff;
      r_in     = r_ff;
      m_in     = m_ff;
      d_in     = d_ff;
      acc_in   = acc_ff;
      yb_in    = yb_ff;
      rb_in    = rb_ff;
      mb_in    = mb_ff;
      db_in    = db_ff;
      cmd_in   = cmd_ff;
      shift_in = shift_ff;
      rsp_in   = rsp_ff;
      case (ctl.op)
         OP_LOAD: begin
            cmd_in   = req_item.cmd;
            shift_in = (req_item.cmd == CMD_ADD) || (ya_s != yb_s);
            y_in     = ya_s;
            r_in     = mod400(req_item.year_a);
            m_in     = ma_c;
            yb_in    = yb_s;
            rb_in    = mod400(req_item.year_b);
            mb_in    = mb_c;
            db_in    = req_item.day_b;
            if (req_item.cmd == CMD_ADD) begin
               d_in   = da_ext + off_ext;
               acc_in = '0;
            end else if (ya_s != yb_s) begin
               d_in   = da_ext + est;
               acc_in = est;
            end else begin
               d_in   = da_ext;
               acc_in = db_ext - da_ext;
            end
         end
         // whole year back: the February crossed belongs to y or y-1
         OP_YDN: begin
            d_in = d_ff + (is_leap((m_ff > MONTH_FEB) ? r_ff : r_dec_a) ? DAYS_LEAP : DAYS_YEAR);
            y_in = y_ff - 16'sd1;
            r_in = r_dec_a;
         end
         // whole year forward
         OP_YUP: begin
            d_in = d_ff - (is_leap((m_ff > MONTH_FEB) ? r_inc_a : r_ff) ? DAYS_LEAP : DAYS_YEAR);
            y_in = y_ff + 16'sd1;
            r_in = r_inc_a;
         end
         // borrow the previous month
         OP_MDN: begin
            m_in = m_dn;
            r_in = r_dn;
            if (m_ff == MONTH_JAN) begin
               y_in = y_ff - 16'sd1;
            end
            d_in = d_ff + ext_days(len_dn);
         end
         // spill into the next month
         OP_MUP: begin
            d_in = d_ff - ext_days(len_a);
            if (m_ff == MONTH_DEC) begin
               m_in = MONTH_JAN;
               y_in = y_ff + 16'sd1;
               r_in = r_inc_a;
            end else begin
               m_in = m_ff + 4'd1;
            end
         end
         // correct the estimate by the day left after the shift
         OP_FIX: begin
            acc_in = acc_ff + $signed({{(DAYS_W-DAY_IN_W){1'b0}}, db_ff}) - d_ff;
         end
         OP_WALKA: begin
            acc_in = acc_ff + ext_days(len_a);
            if (m_ff == MONTH_DEC) begin
               m_in = MONTH_JAN;
               y_in = y_ff + 16'sd1;
               r_in = r_inc_a;
            end else begin
               m_in = m_ff + 4'd1;
            end
         end
         OP_WALKB: begin
            acc_in = acc_ff - ext_days(len_b);
            if (mb_ff == MONTH_DEC) begin
               mb_in = MONTH_JAN;
               yb_in = yb_ff + 16'sd1;
               rb_in = r_inc_b;
            end else begin
               mb_in = mb_ff + 4'd1;
            end
         end
         // saturate and fill the result register
         OP_OUT: begin
            rsp_in = '0;
            if (cmd_ff == CMD_ADD) begin
               rsp_in.result_month = m_ff;
               rsp_in.result_day   = d_ff[DAY_IN_W-1:0];
               if (y_ff < 16'sd0) begin
                  rsp_in.overflow = 1'b1;
               end else if (y_ff > YEAR_MAX) begin
                  rsp_in.result_year = YEAR_MAX[YEAR_IN_W-1:0];
                  rsp_in.overflow    = 1'b1;
               end else begin
                  rsp_in.result_year = y_ff[YEAR_IN_W-1:0];
               end
            end else begin
               if (acc_ff > DIFF_MAX) begin
                  rsp_in.day_difference = DIFF_MAX[OFFSET_W-1:0];
                  rsp_in.overflow       = 1'b1;
               end else if (acc_ff < DIFF_MIN) begin
                  rsp_in.day_difference = DIFF_MIN[OFFSET_W-1:0];
                  rsp_in.overflow       = 1'b1;
               end else begin
                  rsp_in.day_difference = acc_ff[OFFSET_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // mode flags
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= 1'b0;
         shift_ff <= 1'b0;
      end else begin
         cmd_ff   <= cmd_in;
         shift_ff <= shift_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      y_ff   <= y_in;
      r_ff   <= r_in;
      m_ff   <= m_in;
      d_ff   <= d_in;
      acc_ff <= acc_in;
      yb_ff  <= yb_in;
      rb_ff  <= rb_in;
      mb_ff  <= mb_in;
      db_ff  <= db_in;
      rsp_ff <= rsp_in;
   end

   `ASSERT_IMPLY(a_res_range, clock, reset, ctl.op == OP_YUP || ctl.op == OP_YDN, r_ff < RES_MOD)
   `ASSERT_IMPLY(a_month_range, clock, reset, ctl.op == OP_MDN || ctl.op == OP_MUP, m_ff >= MONTH_JAN && m_ff <= MONTH_DEC)
   `ASSERT_IMPLY(a_day_settled, clock, reset, ctl.op == OP_FIX, d_ff >= 25'sd1 && d_ff <= 25'sd31)

endmodule

// ===== hw/rtl/gdad_ctrl.sv =====
`include "assert_macros.svh"

module gdad_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  gdad_pkg::dp_status_type sts,
   output gdad_pkg::ctrl_cmd_type  ctl
);
   import gdad_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_YDN   = 9'b000000010,
      S_YUP   = 9'b000000100,
      S_MDN   = 9'b000001000,
      S_MUP   = 9'b000010000,
      S_FIX   = 9'b000100000,
      S_WALKA = 9'b001000000,
      S_WALKB = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // each loop state repeats its step while its condition holds
   always_comb begin
      state_in = state_ff;
      ctl.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.op   = OP_LOAD;
               state_in = S_YDN;
            end
         end
         S_YDN: begin
            if (!sts.shift_en) begin
               state_in = S_WALKA;
            end else if (sts.d_below_lo) begin
               ctl.op = OP_YDN;
            end else begin
               state_in = S_YUP;
            end
         end
         S_YUP: begin
            if (sts.d_above_hi) begin
               ctl.op = OP_YUP;
            end else begin
               state_in = S_MDN;
            end
         end
         S_MDN: begin
            if (sts.d_below_one) begin
               ctl.op = OP_MDN;
            end else begin
               state_in = S_MUP;
            end
         end
         S_MUP: begin
            if (sts.d_above_len) begin
               ctl.op = OP_MUP;
            end else if (sts.cmd == CMD_DIFF) begin
               state_in = S_FIX;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FIX: begin
            ctl.op   = OP_FIX;
            state_in = S_WALKA;
         end
         S_WALKA: begin
            if (sts.a_before_b) begin
               ctl.op = OP_WALKA;
            end else begin
               state_in = S_WALKB;
            end
         end
         S_WALKB: begin
            if (sts.a_after_b) begin
               ctl.op = OP_WALKB;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctl.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register occupancy
   always_comb begin
      if (ctl.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLY(a_walk_diff_only, clock, reset, state_ff == S_FIX || state_ff == S_WALKA || state_ff == S_WALKB, sts.cmd == CMD_DIFF || !sts.shift_en)
   `ASSERT_NEXT(a_out_sets_valid, clock, reset, ctl.op == OP_OUT, rsp_tvalid)

endmodule

// ===== hw/rtl/gregorian_date_add_and_difference_core.sv =====
// Gregorian date arithmetic core.
// Request channel (req_*): one transfer carries a command in req_tuser and
// two dates plus a signed day offset in req_tdata. Command add shifts date A
// by the offset; command diff returns the signed day count from A to B.
// Result channel (rsp_*): one transfer per request with the shifted date or
// the difference, and an overflow flag for a saturated year or difference.
// Timing: one request at a time. After the load, the sequential stepper
// moves date A by whole years, then by months; diff does so only when the
// years differ, then corrects its estimate and walks the earlier of A and B
// forward by months to the later before the result is written.
// The year/month stepper advances one year or one month per clock.
// Backpressure: a finished result sits in the output register; req_tready
// returns as soon as the result is registered, so the next request can be
// worked on while rsp_tready is low; its result waits until the register
// is taken.
// Reset: synchronous, active high; clears the sequencer and drops rsp_tvalid.
module gregorian_date_add_and_difference_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // year_a[13:0] month_a[17:14] day_a[22:18] day_offset[45:23]
   // year_b[59:46] month_b[63:60] day_b[68:64], zeros above
   input  logic [gdad_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[0]
   input  logic [gdad_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result_year[13:0] result_month[17:14] result_day[22:18]
   // day_difference[45:23] overflow[46], zero above
   output logic [gdad_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import gdad_pkg::*;

   ctrl_cmd_type  ctl;
   dp_status_type sts;
   req_item_type  req_item;
   rsp_item_type  rsp_item;

   // unpack request
   assign req_item.cmd        = req_tuser[0];
   assign req_item.year_a     = req_tdata[13:0];
   assign req_item.month_a    = req_tdata[17:14];
   assign req_item.day_a      = req_tdata[22:18];
   assign req_item.day_offset = req_tdata[45:23];
   assign req_item.year_b     = req_tdata[59:46];
   assign req_item.month_b    = req_tdata[63:60];
   assign req_item.day_b      = req_tdata[68:64];

   // pack result
   assign rsp_tdata = {{(RSP_DATA_W-$bits(rsp_item_type)){1'b0}},
                       rsp_item.overflow, rsp_item.day_difference, rsp_item.result_day,
                       rsp_item.result_month, rsp_item.result_year};

   gdad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   gdad_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_item (req_item),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule

// ===== verif/gregorian_date_add_and_difference_checker.sv =====
// Watches both streams of the date core, predicts each result from the
// accepted request and compares it field by field with what comes back.
module gregorian_date_add_and_difference_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // year_a month_a day_a day_offset year_b month_b day_b, zeros above
   input  logic [gdad_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [gdad_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_year result_month result_day day_difference overflow, zero above
   input  logic [gdad_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              mismatch_count,
   output int                              results_outstanding,
   output int                              results_seen,
   output int                              overflows_seen
);
   import gdad_pkg::*;

   // window for whole-year steps and the fixed part of a year (365 - 28)
   localparam int WINDOW_LO   = -213;
   localparam int WINDOW_HI   = 243;
   localparam int YEAR_NO_FEB = 337;
   localparam int MAX_REPORTS = 10;

   rsp_item_type expected_dates[$];
   rsp_item_type observed;
   rsp_item_type wanted;

   function automatic int days_in_month(input int y, input int m);
      if (m == MONTH_FEB) begin
         return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
      end
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         return 30;
      end
      return 31;
   endfunction

   // months 0 and 13..15 fold onto the nearest real month
   function automatic int fold_month(input logic [MONTH_W-1:0] m);
      if (m < MONTH_JAN) return MONTH_JAN;
      if (m > MONTH_DEC) return MONTH_DEC;
      return int'(m);
   endfunction

   // move a date by a signed day count: whole years first, then months
   function automatic void shift_by_days(input int delta, inout int y, inout int m,
                                         inout int d);
      d = d + delta;
      while (d < WINDOW_LO) begin
         d += YEAR_NO_FEB + days_in_month((m > 2) ? y : y - 1, MONTH_FEB);
         y--;
      end
      while (d > WINDOW_HI) begin
         y++;
         d -= YEAR_NO_FEB + days_in_month((m > 2) ? y : y - 1, MONTH_FEB);
      end
      while (d < 1) begin
         m--;
         if (m < 1) begin
            y--;
            m = 12;
         end
         d += days_in_month(y, m);
      end
      while (d > 28 && d > days_in_month(y, m)) begin
         d -= days_in_month(y, m);
         m++;
         if (m > 12) begin
            y++;
            m = 1;
         end
      end
   endfunction

   // signed day count from the first date to the second
   function automatic int days_between(input int y1, input int m1, input int d1,
                                       input int y2, input int m2, input int d2);
      int gap;
      gap = d2 - d1;
      if (y1 != y2) begin
         // rough estimate, land near the target, then finish by months
         gap += (y2 - y1) * 365 + (m2 - m1) * 30;
         shift_by_days(gap, y1, m1, d1);
         gap += d2 - d1;
      end
      while (y1 < y2 || (y1 == y2 && m1 < m2)) begin
         gap += days_in_month(y1, m1);
         m1++;
         if (m1 > 12) begin
            y1++;
            m1 = 1;
         end
      end
      while (y1 > y2 || (y1 == y2 && m1 > m2)) begin
         gap -= days_in_month(y2, m2);
         m2++;
         if (m2 > 12) begin
            y2++;
            m2 = 1;
         end
      end
      return gap;
   endfunction

   function automatic rsp_item_type predict_date_result(input logic cmd,
                                                        input logic [REQ_DATA_W-1:0] d);
      rsp_item_type r;
      int ya, ma, da, yb, mb, db, offset, span;
      ya     = int'(d[13:0]);
      ma     = fold_month(d[17:14]);
      da     = int'(d[22:18]);
      offset = int'($signed(d[45:23]));
      yb     = int'(d[59:46]);
      mb     = fold_month(d[63:60]);
      db     = int'(d[68:64]);
      r = '0;
      if (cmd == CMD_ADD) begin
         shift_by_days(offset, ya, ma, da);
         // year saturates, month and day stay as computed
         if (ya < 0) begin
            ya = 0;
            r.overflow = 1'b1;
         end else if (ya > YEAR_MAX) begin
            ya = YEAR_MAX;
            r.overflow = 1'b1;
         end
         r.result_year  = YEAR_IN_W'(ya);
         r.result_month = MONTH_W'(ma);
         r.result_day   = DAY_IN_W'(da);
      end else begin
         span = days_between(ya, ma, da, yb, mb, db);
         if (span > DIFF_MAX) begin
            span = DIFF_MAX;
            r.overflow = 1'b1;
         end else if (span < DIFF_MIN) begin
            span = DIFF_MIN;
            r.overflow = 1'b1;
         end
         r.day_difference = OFFSET_W'(span);
      end
      return r;
   endfunction

   // predict on each request transfer, compare on each result transfer
   always @(posedge clock) begin
      if (reset) begin
         expected_dates.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expected_dates.push_back(predict_date_result(req_tuser[0], req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            observed.result_year    = rsp_tdata[13:0];
            observed.result_month   = rsp_tdata[17:14];
            observed.result_day     = rsp_tdata[22:18];
            observed.day_difference = rsp_tdata[45:23];
            observed.overflow       = rsp_tdata[46];
            results_seen   = results_seen + 1;
            overflows_seen = overflows_seen + (observed.overflow === 1'b1);
            if (expected_dates.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("Result transfer %0d arrived with no request outstanding",
                           results_seen);
               end
            end else begin
               wanted = expected_dates.pop_front();
               if (observed.result_year !== wanted.result_year ||
                   observed.result_month !== wanted.result_month ||
                   observed.result_day !== wanted.result_day ||
                   observed.day_difference !== wanted.day_difference ||
                   observed.overflow !== wanted.overflow) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("Result %0d mismatch: expected y=%0d m=%0d d=%0d diff=%0d ovf=%0b",
                              results_seen, wanted.result_year, wanted.result_month,
                              wanted.result_day, $signed(wanted.day_difference),
                              wanted.overflow);
                     $display("   got y=%0d m=%0d d=%0d diff=%0d ovf=%0b",
                              observed.result_year, observed.result_month,
                              observed.result_day, $signed(observed.day_difference),
                              observed.overflow);
                  end
               end
            end
         end
      end
      results_outstanding = expected_dates.size();
   end

endmodule

// ===== verif/gregorian_date_add_and_difference_core_tb.sv =====
// Stimulus and verdict for the date core; checking lives in the checker.
module gregorian_date_add_and_difference_core_tb;
   import gdad_pkg::*;

   localparam int HOLD_CYCLES       = 600;
   localparam int SETTLE_CYCLES     = 200;
   // slowest request (widest difference) plus idling, for every request sent
   localparam int WORST_ITEM_CYCLES = 17000;
   localparam int ITEM_BUDGET       = 140;
   localparam int CYCLE_LIMIT       = ITEM_BUDGET * (WORST_ITEM_CYCLES + 64) * 3
                                      + HOLD_CYCLES * 4;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   bit send_gaps    = 1'b1;
   bit sink_stalls  = 1'b1;
   bit hold_request = 1'b0;

   int adds_sent;
   int diffs_sent;
   int cycle_count;
   int mismatch_count;
   int results_outstanding;
   int results_seen;
   int overflows_seen;

   gregorian_date_add_and_difference_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   gregorian_date_add_and_difference_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tuser           (req_tuser),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding),
      .results_seen        (results_seen),
      .overflows_seen      (overflows_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, results_outstanding);
      $display("FAIL");
      $finish;
   end

   // result side: random stalls, or one long hold-off when asked for
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready   = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready = !sink_stalls || ($urandom_range(0, 99) >= 9);
      end
   end

   function automatic req_item_type date_request(input logic cmd, input int ya, input int ma,
                                                 input int da, input int offset, input int yb,
                                                 input int mb, input int db);
      req_item_type it;
      it.cmd        = cmd;
      it.year_a     = YEAR_IN_W'(ya);
      it.month_a    = MONTH_W'(ma);
      it.day_a      = DAY_IN_W'(da);
      it.day_offset = OFFSET_W'(offset);
      it.year_b     = YEAR_IN_W'(yb);
      it.month_b    = MONTH_W'(mb);
      it.day_b      = DAY_IN_W'(db);
      return it;
   endfunction

   // mostly plausible dates with short spans, some wide spans, some raw bits
   function automatic req_item_type random_request();
      req_item_type it;
      int yr, yb, offset;
      it.cmd = CMD_ADD;
      if ($urandom_range(0, 1) == 1) it.cmd = CMD_DIFF;
      if ($urandom_range(0, 99) < 20) begin
         it.year_a     = YEAR_IN_W'($urandom);
         it.month_a    = MONTH_W'($urandom);
         it.day_a      = DAY_IN_W'($urandom);
         it.day_offset = OFFSET_W'($urandom);
         it.year_b     = YEAR_IN_W'($urandom);
         it.month_b    = MONTH_W'($urandom);
         it.day_b      = DAY_IN_W'($urandom);
      end else begin
         yr = int'($urandom_range(1, 9999));
         case ($urandom_range(0, 9))
            0:       offset = int'($signed(OFFSET_W'($urandom)));
            1, 2:    offset = int'($urandom_range(0, 80000)) - 40000;
            default: offset = int'($urandom_range(0, 1400)) - 700;
         endcase
         if ($urandom_range(0, 4) == 0) begin
            yb = yr;
         end else begin
            yb = yr + int'($urandom_range(0, 120)) - 60;
            if (yb < 0) yb = 0;
            if (yb > 9999) yb = 9999;
         end
         it = date_request(it.cmd, yr, $urandom_range(1, 12), $urandom_range(1, 31), offset,
                           yb, $urandom_range(1, 12), $urandom_range(1, 31));
      end
      return it;
   endfunction

   // offer one request, hold it until the transfer, return at the next falling edge
   task automatic offer_request(input req_item_type it);
      if (send_gaps && $urandom_range(0, 99) < 9) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.cmd;
      req_tdata  = {3'b000, it.day_b, it.month_b, it.year_b, it.day_offset,
                    it.day_a, it.month_a, it.year_a};
      do @(posedge clock); while (!req_tready);
      if (it.cmd == CMD_ADD) adds_sent++;
      else diffs_sent++;
      @(negedge clock);
   endtask

   task automatic offer_random(input int count);
      repeat (count) offer_request(random_request());
   endtask

   initial begin
      adds_sent  = 0;
      diffs_sent = 0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      reset      = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // calendar edges: leap rules, year wrap, step window borders
      offer_request(date_request(CMD_ADD, 2000, 2, 28, 1, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 1900, 2, 28, 1, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 2023, 12, 31, 1, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 2024, 1, 1, -1, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 2000, 1, 31, 29, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 2001, 1, 1, 242, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 2001, 1, 1, 243, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 2001, 1, 1, -214, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 2001, 1, 1, -215, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 1999, 6, 15, 0, 0, 0, 0));
      // day past month end, month and day zero, out-of-range input year
      offer_request(date_request(CMD_ADD, 2021, 4, 31, 0, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 5, 0, 0, 0, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 16383, 15, 31, 0, 0, 0, 0));
      // year saturation at both ends, extreme offsets
      offer_request(date_request(CMD_ADD, 0, 1, 1, -1, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 9999, 12, 31, 1, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 0, 1, 1, 4194303, 0, 0, 0));
      offer_request(date_request(CMD_ADD, 9999, 12, 31, -4194304, 0, 0, 0));
      // differences: equal, same year backwards, across years both ways
      offer_request(date_request(CMD_DIFF, 2024, 2, 29, 0, 2024, 2, 29));
      offer_request(date_request(CMD_DIFF, 2024, 11, 15, 0, 2024, 3, 1));
      offer_request(date_request(CMD_DIFF, 2000, 3, 1, 0, 2024, 2, 29));
      offer_request(date_request(CMD_DIFF, 2024, 2, 29, 0, 1600, 13, 0));
      // difference saturation both ways, and the widest in-range span
      offer_request(date_request(CMD_DIFF, 0, 1, 1, 0, 16383, 12, 31));
      offer_request(date_request(CMD_DIFF, 16383, 15, 31, 0, 0, 0, 0));
      offer_request(date_request(CMD_DIFF, 9999, 12, 31, 0, 0, 1, 1));

      offer_random(25);

      // drain fully, then stall the result side while short adds keep coming
      req_tvalid = 1'b0;
      wait (results_outstanding == 0);
      @(negedge clock);
      hold_request = 1'b1;
      repeat (8) begin
         offer_request(date_request(CMD_ADD, $urandom_range(1, 9999), $urandom_range(1, 12),
                                    $urandom_range(1, 28), int'($urandom_range(0, 60)) - 30,
                                    0, 0, 0));
      end

      // a stretch with no idling on either side
      send_gaps   = 1'b0;
      sink_stalls = 1'b0;
      offer_random(22);
      send_gaps   = 1'b1;
      sink_stalls = 1'b1;
      offer_random(22);

      req_tvalid = 1'b0;
      wait (results_outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d add and %0d difference requests; %0d results checked, %0d overflowed.",
               adds_sent, diffs_sent, results_seen, overflows_seen);
      $display("Included calendar edges, saturation both ways and a %0d-cycle result hold-off.",
               HOLD_CYCLES);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== gregorian_date_add_and_difference_core.f =====
+incdir+hw/rtl
hw/rtl/gdad_pkg.sv
hw/rtl/gdad_datapath.sv
hw/rtl/gdad_ctrl.sv
hw/rtl/gregorian_date_add_and_difference_core.sv
verif/gregorian_date_add_and_difference_checker.sv
verif/gregorian_date_add_and_difference_core_tb.sv
